/* rtl/assert_macros.svh */
// Assertion helpers shared by the decoder modules.
// Without SYNTH defined the checks are live; with SYNTH defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* rtl/u8sd_pkg.sv */
package u8sd_pkg;

  // Default depth of the queue between the front and the back
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned CpW    = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned OwedW  = 2;
  localparam int unsigned LeadW  = 7;
  localparam int unsigned ContW  = 6;

  // Lead byte patterns
  localparam logic [7:0] Lead2Mask = 8'b1110_0000;
  localparam logic [7:0] Lead2Code = 8'b1100_0000;
  localparam logic [7:0] Lead3Mask = 8'b1111_0000;
  localparam logic [7:0] Lead3Code = 8'b1110_0000;
  localparam logic [7:0] Lead4Mask = 8'b1111_1000;
  localparam logic [7:0] Lead4Code = 8'b1111_0000;
  localparam logic [7:0] ContMask  = 8'b0011_1111;
  localparam logic [7:0] ByteMask  = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_length;
    logic            is_newline;
    logic            is_space;
    logic            truncated;
    logic            text_done;
  } out_t;

  // Byte classified both ways: as a lead and as a continuation
  typedef struct packed {
    logic [LenW-1:0]  lead_len;
    logic [LeadW-1:0] lead_val;
    logic [ContW-1:0] cont_bits;
    logic             eot;
  } entry_t;

  function automatic logic [LenW-1:0] lead_length(input logic [7:0] b);
    logic [LenW-1:0] len;
    if ((b & Lead2Mask) == Lead2Code) begin
      len = 3'd2;
    end else if ((b & Lead3Mask) == Lead3Code) begin
      len = 3'd3;
    end else if ((b & Lead4Mask) == Lead4Code) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic logic [LeadW-1:0] lead_value(input logic [7:0] b,
                                                  input logic [LenW-1:0] len);
    logic [7:0] m;
    m = b & (ByteMask >> len);
    return m[LeadW-1:0];
  endfunction

  function automatic logic cp_newline(input logic [CpW-1:0] c);
    return c inside {[21'h0A:21'h0D], 21'h85, 21'h2028, 21'h2029};
  endfunction

  function automatic logic cp_space(input logic [CpW-1:0] c);
    return cp_newline(c) ||
           (c inside {21'h09, 21'h20, 21'hA0, 21'h1680, [21'h2000:21'h200A],
                      21'h202F, 21'h205F, 21'h3000});
  endfunction

endpackage

/* rtl/u8sd_front.sv */
module u8sd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  u8sd_pkg::in_t   in_data_i,
  output logic            ent_valid_o,
  output u8sd_pkg::entry_t ent_o,
  input  logic            ent_full_i
);
  import u8sd_pkg::*;

  logic   ent_valid_q, ent_valid_d;
  entry_t ent_q, ent_d;
  logic   in_take;
  logic   ent_push;

  // Hold the classified transaction while the queue is full
  assign in_stall_o = ent_valid_q & ent_full_i;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign ent_push   = ent_valid_q & ~ent_full_i;

  // Classify the byte as lead and as continuation
  always_comb begin
    ent_valid_d = ent_valid_q;
    ent_d       = ent_q;
    if (in_take) begin
      ent_valid_d     = 1'b1;
      ent_d.lead_len  = lead_length(in_data_i.data_byte);
      ent_d.lead_val  = lead_value(in_data_i.data_byte, ent_d.lead_len);
      ent_d.cont_bits = in_data_i.data_byte[ContW-1:0];
      ent_d.eot       = in_data_i.end_of_text;
    end else if (ent_push) begin
      ent_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else begin
      ent_valid_q <= ent_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_valid_o = ent_valid_q;
  assign ent_o       = ent_q;

endmodule

/* rtl/u8sd_queue.sv */
`include "assert_macros.svh"

module u8sd_queue #(
  parameter int unsigned Depth = u8sd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  u8sd_pkg::entry_t push_data_i,
  output logic             full_o,
  output logic             pop_valid_o,
  output u8sd_pkg::entry_t pop_data_o,
  input  logic             pop_i
);
  import u8sd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign push        = push_valid_i & ~full_o;
  assign pop         = pop_i & pop_valid_o;
  assign pop_data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_count_over, clk_i, rst_ni, count_q > CntW'(Depth), "queue count overflow")
  `ASSERT_AT(a_push_fills, clk_i, rst_ni, push && !pop |=> count_q != '0, "push lost")
  `ASSERT_AT(a_pop_frees, clk_i, rst_ni, pop && !push |=> !full_o, "pop did not free a slot")

endmodule

/* rtl/u8sd_back.sv */
`include "assert_macros.svh"

module u8sd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ent_valid_i,
  input  u8sd_pkg::entry_t ent_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output u8sd_pkg::out_t   out_data_o
);
  import u8sd_pkg::*;

  logic [CpW-1:0]   accum_q, accum_d;
  logic [OwedW-1:0] owed_q, owed_d;
  logic [LenW-1:0]  total_q, total_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  logic             take;
  logic             emit_done;
  logic             emit_trunc;
  logic [CpW-1:0]   next_accum;
  logic [OwedW-1:0] next_owed;
  logic [LenW-1:0]  next_total;

  // Take a queued entry whenever the output register can accept a result
  assign take  = ent_valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o = take;

  // Fold the byte into the open sequence or start a new one
  always_comb begin
    if (owed_q == '0) begin
      next_accum = {{(CpW - LeadW){1'b0}}, ent_i.lead_val};
      next_total = ent_i.lead_len;
      next_owed  = OwedW'(ent_i.lead_len - 3'd1);
    end else begin
      next_accum = {accum_q[CpW-ContW-1:0], ent_i.cont_bits};
      next_total = total_q;
      next_owed  = owed_q - 1'b1;
    end
    emit_done  = (next_owed == '0);
    emit_trunc = ~emit_done & ent_i.eot;
  end

  // Update the sequence state and the result register
  always_comb begin
    accum_d     = accum_q;
    owed_d      = owed_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      accum_d = next_accum;
      owed_d  = next_owed;
      total_d = next_total;
      if (emit_done || emit_trunc) begin
        out_valid_d      = 1'b1;
        out_d.code_point = next_accum;
        out_d.is_newline = cp_newline(next_accum);
        out_d.is_space   = cp_space(next_accum);
        out_d.truncated  = emit_trunc;
        out_d.text_done  = ent_i.eot;
        out_d.seq_length = emit_done ? next_total : next_total - {1'b0, next_owed};
      end
      // Drop the partial sequence once the text has ended
      if (emit_trunc) begin
        accum_d = '0;
        owed_d  = '0;
        total_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q     <= '0;
      owed_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      accum_q     <= accum_d;
      owed_q      <= owed_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_AT(a_owed_below_total, clk_i, rst_ni, owed_q != '0 |-> total_q > {1'b0, owed_q}, "owed count exceeds sequence length")
  `ASSERT_AT(a_trunc_is_done, clk_i, rst_ni, out_valid_q && out_q.truncated |-> out_q.text_done, "truncated result without text end")
  `ASSERT_AT(a_trunc_clears, clk_i, rst_ni, take && emit_trunc |=> owed_q == '0, "state not cleared after truncation")

endmodule

/* rtl/utf8_stream_decoder_core.sv */
// UTF-8 stream decoder: takes one text byte per transaction and returns one result per
// complete codepoint (value, byte length, newline and whitespace flags), or a result marked
// truncated when the text ends inside a sequence. It sustains one byte per clock cycle
// while nothing stalls; a byte passes through the front entry register, the queue storage
// and the back end result register, and the queue between front and back (QUEUE_DEPTH
// entries) absorbs output stalls before the input stalls.
module utf8_stream_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = u8sd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  u8sd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output u8sd_pkg::out_t out_data_o
);
  import u8sd_pkg::*;

  logic   fr_valid;
  entry_t fr_ent;
  logic   q_full;
  logic   q_valid;
  entry_t q_ent;
  logic   q_pop;

  // Accept and classify bytes
  u8sd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .ent_valid_o (fr_valid),
    .ent_o       (fr_ent),
    .ent_full_i  (q_full)
  );

  // Decouple front and back
  u8sd_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_data_i  (fr_ent),
    .full_o       (q_full),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_ent),
    .pop_i        (q_pop)
  );

  // Accumulate codepoints and produce results
  u8sd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (q_valid),
    .ent_i       (q_ent),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/utf8_stream_decoder_core_tb.sv */
`timescale 1ns / 1ps

module utf8_stream_decoder_core_tb;
  import u8sd_pkg::*;

  // Marker bits of a continuation byte
  localparam logic [7:0] ContCode = 8'b1000_0000;
  // No end-of-text marker inside a sequence
  localparam int NoCut = -1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // Decoder state as predicted
  logic [CpW-1:0]   dec_accum = '0;
  logic [OwedW-1:0] dec_owed = '0;
  logic [LenW-1:0]  dec_total = '0;

  out_t pending_code_points [$];
  int   mismatch_count = 0;
  int   bytes_sent = 0;
  bit   idle_on = 1'b1;

  utf8_stream_decoder_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the predicted decoder by one byte and queue any codepoint it yields
  task automatic predict_byte(input in_t item);
    logic [LenW-1:0] len;
    logic [CpW-1:0]  c;
    logic            nl;
    out_t            res;
    bit              emit;
    emit = 1'b0;
    res = '0;
    if (dec_owed == '0) begin
      if ((item.data_byte & Lead2Mask) == Lead2Code) begin
        len = 3'd2;
      end else if ((item.data_byte & Lead3Mask) == Lead3Code) begin
        len = 3'd3;
      end else if ((item.data_byte & Lead4Mask) == Lead4Code) begin
        len = 3'd4;
      end else begin
        len = 3'd1;
      end
      dec_accum = CpW'(item.data_byte & (ByteMask >> len));
      dec_total = len;
      dec_owed  = OwedW'(len - 3'd1);
    end else begin
      // Take any byte as a continuation, top bits unchecked
      dec_accum = {dec_accum[CpW-7:0], 6'(item.data_byte & ContMask)};
      dec_owed  = dec_owed - 2'd1;
    end
    c = dec_accum;
    if (dec_owed == '0) begin
      res.seq_length = dec_total;
      res.text_done  = item.end_of_text;
      emit = 1'b1;
    end else if (item.end_of_text) begin
      // Text ended inside a sequence: flush the partial value and return to idle
      res.seq_length = dec_total - LenW'(dec_owed);
      res.truncated  = 1'b1;
      res.text_done  = 1'b1;
      emit = 1'b1;
      dec_accum = '0;
      dec_owed  = '0;
      dec_total = '0;
    end
    if (emit) begin
      nl = (c >= 21'h0A && c <= 21'h0D) || c == 21'h85 || c == 21'h2028 || c == 21'h2029;
      res.code_point = c;
      res.is_newline = nl;
      res.is_space   = nl || c == 21'h09 || c == 21'h20 || c == 21'hA0 || c == 21'h1680 ||
                       (c >= 21'h2000 && c <= 21'h200A) || c == 21'h202F ||
                       c == 21'h205F || c == 21'h3000;
      pending_code_points.push_back(res);
    end
  endtask

  // Offer one byte, hold it until the transaction completes, then predict
  task automatic send_byte(input logic [7:0] data, input logic last);
    in_t item;
    item.data_byte   = data;
    item.end_of_text = last;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_byte(item);
    bytes_sent++;
  endtask

  // Encode a codepoint in len bytes; mark end of text on byte cut and stop there
  task automatic send_code_point(input logic [CpW-1:0] cp, input int len, input int cut);
    logic [7:0] seq [4];
    int i;
    case (len)
      1: begin
        seq[0] = {1'b0, cp[6:0]};
      end
      2: begin
        seq[0] = Lead2Code | {3'b0, cp[10:6]};
      end
      3: begin
        seq[0] = Lead3Code | {4'b0, cp[15:12]};
      end
      default: begin
        seq[0] = Lead4Code | {5'b0, cp[20:18]};
      end
    endcase
    for (i = 1; i < len; i++) begin
      seq[i] = ContCode | {2'b0, 6'(cp >> (6 * (len - 1 - i)))};
    end
    for (i = 0; i < len; i++) begin
      send_byte(seq[i], i == cut);
      if (i == cut) begin
        break;
      end
    end
  endtask

  // Mostly well-formed text with random content, some class probes and raw noise
  task automatic gen_random_text(input int n);
    int stop_at;
    int r;
    int len;
    int cut;
    logic [CpW-1:0] cp;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        send_byte(8'($urandom), $urandom_range(0, 15) == 0);
      end else begin
        len = $urandom_range(1, 4);
        cp  = CpW'($urandom) & CpW'((1 << (len == 1 ? 7 : 5 * len + 1)) - 1);
        if (r < 4) begin
          case ($urandom_range(0, 15))
            0:  cp = 21'h09;
            1:  cp = 21'h0A + CpW'($urandom_range(0, 3));
            2:  cp = 21'h20;
            3:  cp = 21'h85;
            4:  cp = 21'hA0;
            5:  cp = 21'h1680;
            6:  cp = 21'h2000 + CpW'($urandom_range(0, 11));
            7:  cp = 21'h2028;
            8:  cp = 21'h2029;
            9:  cp = 21'h202F;
            10: cp = 21'h205F;
            11: cp = 21'h3000;
            12: cp = 21'h0E;
            13: cp = 21'h08;
            14: cp = 21'h2027;
            default: cp = 21'h1FFF;
          endcase
          len = cp < 21'h80 ? 1 : (cp < 21'h800 ? 2 : 3);
        end
        case ($urandom_range(0, 11))
          0: cut = $urandom_range(0, len - 1);
          1: cut = len - 1;
          default: cut = NoCut;
        endcase
        send_code_point(cp, len, cut);
      end
    end
  endtask

  task automatic test_single_byte();
    send_code_point(21'h00, 1, NoCut);
    send_code_point(21'h7F, 1, NoCut);
    send_code_point(21'h09, 1, NoCut);
  endtask

  task automatic test_multibyte();
    send_code_point(21'h85, 2, NoCut);
    send_code_point(21'h2028, 3, NoCut);
    send_code_point(21'h3000, 3, NoCut);
    send_code_point(21'h1FFFFF, 4, NoCut);
  endtask

  // Stray continuation, invalid lead, then a continuation with the wrong top bits
  task automatic test_malformed();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  // End of text inside a sequence, on a lone lead, and on a complete codepoint
  task automatic test_truncation();
    send_code_point(21'h2028, 3, 1);
    send_code_point(21'h10000, 4, 0);
    send_code_point(21'h0A, 1, 0);
  endtask

  // Alternate stretches with and without idling on both sides
  task automatic test_random_text();
    int seg;
    for (seg = 0; seg < 8; seg++) begin
      idle_on = (seg % 3) != 2;
      gen_random_text(40);
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    gen_random_text(80);
  endtask

  // Random output stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // Compare each output transaction with the oldest predicted codepoint
  always @(posedge clk_i) begin : check_results
    out_t exp_r;
    bit   bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_code_points.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: cp=%h len=%0d", out_data_o.code_point,
                   out_data_o.seq_length);
        end
        mismatch_count++;
      end else begin
        exp_r = pending_code_points.pop_front();
        bad = (out_data_o.code_point !== exp_r.code_point) ||
              (out_data_o.seq_length !== exp_r.seq_length) ||
              (out_data_o.is_newline !== exp_r.is_newline) ||
              (out_data_o.is_space !== exp_r.is_space) ||
              (out_data_o.truncated !== exp_r.truncated) ||
              (out_data_o.text_done !== exp_r.text_done);
        if (bad) begin
          if (mismatch_count < 10) begin
            $display("mismatch: exp cp=%h len=%0d nl=%b sp=%b tr=%b dn=%b",
                     exp_r.code_point, exp_r.seq_length, exp_r.is_newline,
                     exp_r.is_space, exp_r.truncated, exp_r.text_done);
            $display("          got cp=%h len=%0d nl=%b sp=%b tr=%b dn=%b",
                     out_data_o.code_point, out_data_o.seq_length, out_data_o.is_newline,
                     out_data_o.is_space, out_data_o.truncated, out_data_o.text_done);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_byte();
    test_multibyte();
    test_malformed();
    test_truncation();
    test_random_text();
    test_back_to_back();
    in_valid_i <= 1'b0;
    // Drain outstanding codepoints, then keep watching for strays
    while (pending_code_points.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
